// ===== hdl/br1_rld_pkg.sv =====
`default_nettype none

package br1_rld_pkg;

   // decoded-byte counter, frame size register and run length widths
   localparam int COUNT_WIDTH      = 24;
   localparam int FRAME_SIZE_WIDTH = 24;
   localparam int RUN_WIDTH        = 8;

   localparam logic [FRAME_SIZE_WIDTH-1:0] FRAME_SIZE_RESET = FRAME_SIZE_WIDTH'(8000);

   // control byte that does nothing
   localparam logic [7:0] CTRL_NOP = 8'h80;

   // byte_count codes
   localparam logic [1:0] BYTES_ONE = 2'd1;
   localparam logic [1:0] BYTES_TWO = 2'd2;

   // controller -> datapath commands
   typedef struct packed {
      logic load_lit;      // literal control byte: run = n + 1
      logic load_rep;      // repeat control byte: run = 257 - n
      logic capture_data;  // hold the byte to be repeated
      logic emit_lit;      // pass one literal byte to the output
      logic drop_step;     // swallow one literal byte after frame end
      logic emit_rep;      // emit one or two repeated bytes
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic out_free;      // output register can take an item this cycle
      logic ctrl_literal;  // incoming byte is a literal control byte
      logic ctrl_nop;      // incoming byte is the no-op control byte
      logic run_last;      // one byte left in the current run
      logic lit_frame_end; // next counted byte completes the frame
      logic rep_last;      // this repeat step is the last of the run
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/br1_rld_ctrl.sv =====
`default_nettype none

module br1_rld_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire br1_rld_pkg::status_type status,
   output      br1_rld_pkg::cmd_type    cmd
);
   import br1_rld_pkg::*;

   typedef enum logic [2:0] {
      ST_CONTROL,
      ST_LITERAL,
      ST_DROP,
      ST_REP_DATA,
      ST_REP_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid & req_ready;

   // ready and commands per state
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_CONTROL: begin
            req_ready = 1'b1;
            if (accept) begin
               if (status.ctrl_literal) begin
                  cmd.load_lit = 1'b1;
                  state_in     = ST_LITERAL;
               end else if (!status.ctrl_nop) begin
                  cmd.load_rep = 1'b1;
                  state_in     = ST_REP_DATA;
               end
            end
         end
         ST_LITERAL: begin
            req_ready = status.out_free;
            if (accept) begin
               cmd.emit_lit = 1'b1;
               if (status.run_last) begin
                  state_in = ST_CONTROL;
               end else if (status.lit_frame_end) begin
                  state_in = ST_DROP;
               end
            end
         end
         ST_DROP: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.drop_step = 1'b1;
               if (status.run_last) begin
                  state_in = ST_CONTROL;
               end
            end
         end
         ST_REP_DATA: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.capture_data = 1'b1;
               state_in         = ST_REP_EMIT;
            end
         end
         ST_REP_EMIT: begin
            if (status.out_free) begin
               cmd.emit_rep = 1'b1;
               if (status.rep_last) begin
                  state_in = ST_CONTROL;
               end
            end
         end
         default: begin
            state_in = ST_CONTROL;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CONTROL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/br1_rld_datapath.sv =====
`default_nettype none

module br1_rld_datapath (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic [7:0]                                req_in_byte,
   input  wire logic                                      csr_valid,
   output      logic                                      csr_ready,
   input  wire logic [br1_rld_pkg::FRAME_SIZE_WIDTH-1:0]  csr_frame_size,
   output      logic                                      rsp_valid,
   input  wire logic                                      rsp_ready,
   output      logic [7:0]                                rsp_first_byte,
   output      logic [7:0]                                rsp_second_byte,
   output      logic [1:0]                                rsp_byte_count,
   output      logic                                      rsp_last_of_run,
   output      logic                                      rsp_frame_end,
   input  wire br1_rld_pkg::cmd_type                      cmd,
   output      br1_rld_pkg::status_type                   status
);
   import br1_rld_pkg::*;

   logic [FRAME_SIZE_WIDTH-1:0] frame_size_ff;
   logic [COUNT_WIDTH-1:0]      count_ff;
   logic [COUNT_WIDTH-1:0]      count_in;
   logic [RUN_WIDTH-1:0]        run_ff;
   logic [RUN_WIDTH-1:0]        run_in;
   logic [7:0]                  data_ff;

   logic                        rsp_valid_ff;
   logic [7:0]                  first_ff;
   logic [7:0]                  second_ff;
   logic [1:0]                  count_code_ff;
   logic                        last_ff;
   logic                        frame_end_ff;

   logic [COUNT_WIDTH-1:0]      frame_limit;
   logic [COUNT_WIDTH-1:0]      count_plus1;
   logic [COUNT_WIDTH-1:0]      count_plus2;
   logic                        fe1;
   logic                        fe2;

   // repeat step results
   logic                        rep_two;
   logic                        rep_fe;
   logic [RUN_WIDTH-1:0]        rep_run;
   logic [COUNT_WIDTH-1:0]      rep_count;

   logic                        emit;
   logic [8:0]                  rep_len;

   assign csr_ready   = 1'b1;
   assign frame_limit = COUNT_WIDTH'(frame_size_ff);
   assign count_plus1 = count_ff + COUNT_WIDTH'(1);
   assign count_plus2 = count_ff + COUNT_WIDTH'(2);
   assign fe1         = (count_plus1 == frame_limit);
   assign fe2         = (count_plus2 == frame_limit);
   assign emit        = cmd.emit_lit | cmd.emit_rep;
   assign rep_len     = 9'd257 - {1'b0, req_in_byte};

   // one repeat step: stops short at the frame end or at the run end
   always_comb begin
      if (fe1) begin
         rep_two   = 1'b0;
         rep_fe    = 1'b1;
         rep_run   = '0;
         rep_count = '0;
      end else if (run_ff == RUN_WIDTH'(1)) begin
         rep_two   = 1'b0;
         rep_fe    = 1'b0;
         rep_run   = '0;
         rep_count = count_plus1;
      end else begin
         rep_two   = 1'b1;
         rep_fe    = fe2;
         rep_run   = fe2 ? '0 : run_ff - RUN_WIDTH'(2);
         rep_count = fe2 ? '0 : count_plus2;
      end
   end

   // status to the controller
   always_comb begin
      status.out_free      = !rsp_valid_ff || rsp_ready;
      status.ctrl_literal  = (req_in_byte < CTRL_NOP);
      status.ctrl_nop      = (req_in_byte == CTRL_NOP);
      status.run_last      = (run_ff == RUN_WIDTH'(1));
      status.lit_frame_end = fe1;
      status.rep_last      = (rep_run == '0);
   end

   // run length and byte counter next values
   always_comb begin
      run_in   = run_ff;
      count_in = count_ff;
      if (cmd.load_lit) begin
         run_in = RUN_WIDTH'({1'b0, req_in_byte} + 9'd1);
      end else if (cmd.load_rep) begin
         run_in = RUN_WIDTH'(rep_len);
      end else if (cmd.emit_lit) begin
         run_in   = run_ff - RUN_WIDTH'(1);
         count_in = fe1 ? '0 : count_plus1;
      end else if (cmd.drop_step) begin
         run_in = run_ff - RUN_WIDTH'(1);
      end else if (cmd.emit_rep) begin
         run_in   = rep_run;
         count_in = rep_count;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RESET;
         count_ff      <= '0;
         run_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            frame_size_ff <= csr_frame_size;
         end
         count_ff <= count_in;
         run_ff   <= run_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture_data) begin
         data_ff <= req_in_byte;
      end
      if (cmd.emit_lit) begin
         first_ff      <= req_in_byte;
         second_ff     <= 8'h00;
         count_code_ff <= BYTES_ONE;
         last_ff       <= 1'b1;
         frame_end_ff  <= fe1;
      end else if (cmd.emit_rep) begin
         first_ff      <= data_ff;
         second_ff     <= rep_two ? data_ff : 8'h00;
         count_code_ff <= rep_two ? BYTES_TWO : BYTES_ONE;
         last_ff       <= (rep_run == '0);
         frame_end_ff  <= rep_fe;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_byte  = first_ff;
   assign rsp_second_byte = second_ff;
   assign rsp_byte_count  = count_code_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_end   = frame_end_ff;

endmodule

`default_nettype wire

// ===== hdl/byterun1_run_length_decoder_unit.sv =====
// ByteRun1 (PackBits) run-length decoder.
// Input channel req_*: one compressed byte per item. Output channel rsp_*:
// one or two decoded bytes per item, with last_of_run marking the final
// item caused by an input byte and frame_end marking the item that
// reaches the frame size. Config channel csr_*: frame size (reset 8000),
// always ready; write it only while the decoder is idle.
// Flow: control and dropped bytes give no output. A literal byte gives its
// item in the cycle after acceptance; literals can
// be taken every cycle while the output register keeps draining.
// A repeat takes its data byte, then emits one two-byte item per cycle
// while the receiver keeps up (the last may carry one byte); no input is taken meanwhile.
// The single output register sets the stepping: a stalled receiver
// holds the current item and pauses literal input and repeat emission.
// At frame end the rest of the current run is swallowed and the byte
// counter clears. Synchronous reset returns to expecting a control byte,
// clears the counters and restores the default frame size.
`default_nettype none

module byterun1_run_length_decoder_unit (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output      logic                                     req_ready,
   input  wire logic [7:0]                               req_in_byte,
   output      logic                                     rsp_valid,
   input  wire logic                                     rsp_ready,
   output      logic [7:0]                               rsp_first_byte,
   output      logic [7:0]                               rsp_second_byte,
   output      logic [1:0]                               rsp_byte_count,
   output      logic                                     rsp_last_of_run,
   output      logic                                     rsp_frame_end,
   input  wire logic                                     csr_valid,
   output      logic                                     csr_ready,
   input  wire logic [br1_rld_pkg::FRAME_SIZE_WIDTH-1:0] csr_frame_size
);
   import br1_rld_pkg::*;

   cmd_type    cmd;
   status_type status;

   br1_rld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   br1_rld_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_frame_size  (csr_frame_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

// ===== hdl/br1_rld_checker.sv =====
`default_nettype none

module br1_rld_checker (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     rsp_valid,
   input wire logic                                     rsp_ready,
   input wire logic [7:0]                               rsp_first_byte,
   input wire logic [7:0]                               rsp_second_byte,
   input wire logic [1:0]                               rsp_byte_count,
   input wire logic                                     rsp_last_of_run,
   input wire logic                                     rsp_frame_end
);
   import br1_rld_pkg::*;

   // no item is left showing after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output item valid after reset");

   // a stalled item holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_byte)
         && $stable(rsp_second_byte) && $stable(rsp_byte_count)
         && $stable(rsp_last_of_run) && $stable(rsp_frame_end))
      else $error("stalled output item changed");

   // two-byte items only come from repeats, so both bytes match
   a_pair_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == BYTES_TWO |-> rsp_second_byte == rsp_first_byte)
      else $error("two-byte item with differing bytes");

   // a single-byte item has a cleared second byte
   a_single_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == BYTES_ONE |-> rsp_second_byte == 8'h00)
      else $error("single-byte item with non-zero second byte");

   // only a run's last item may be short or end the frame; all others carry two bytes
   a_mid_run_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_byte_count == BYTES_TWO && !rsp_frame_end)
      else $error("mid-run item not a full pair");

endmodule

bind byterun1_run_length_decoder_unit br1_rld_checker u_br1_rld_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   import br1_rld_pkg::*;

   // control byte codes and run limits
   localparam logic [7:0] CTRL_LIT_SHORTEST = 8'h00;  // literal run of one byte
   localparam logic [7:0] CTRL_LIT_LONGEST  = 8'h7F;  // literal run of 128 bytes
   localparam logic [7:0] CTRL_REP_LONGEST  = 8'h81;  // repeat of 128 bytes
   localparam logic [7:0] CTRL_REP_SHORTEST = 8'hFF;  // repeat of 2 bytes
   localparam int         OUT_LANES         = 2;
   localparam int         MAX_RESULTS       = 64;
   localparam int         SETTLE_CYCLES     = 8;

   localparam logic [FRAME_SIZE_WIDTH-1:0] FRAME_SIZE_MIN = FRAME_SIZE_WIDTH'(1);
   localparam logic [FRAME_SIZE_WIDTH-1:0] FRAME_SIZE_MAX = {FRAME_SIZE_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      DEC_CONTROL,
      DEC_LITERAL,
      DEC_REPEAT,
      DEC_DROP
   } dec_phase_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic       last_of_run;
      logic       frame_end;
   } decoded_item_type;

   logic                        clock;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic [7:0]                  req_in_byte    = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic [7:0]                  rsp_first_byte;
   logic [7:0]                  rsp_second_byte;
   logic [1:0]                  rsp_byte_count;
   logic                        rsp_last_of_run;
   logic                        rsp_frame_end;
   logic                        csr_valid      = 1'b0;
   logic                        csr_ready;
   logic [FRAME_SIZE_WIDTH-1:0] csr_frame_size = FRAME_SIZE_RESET;

   // decoder state as predicted
   dec_phase_type               dec_phase     = DEC_CONTROL;
   logic [RUN_WIDTH-1:0]        run_left      = '0;
   logic [COUNT_WIDTH-1:0]      bytes_written = '0;
   logic [FRAME_SIZE_WIDTH-1:0] frame_size    = FRAME_SIZE_RESET;

   decoded_item_type            decoded_q[$];
   int                          fail_count    = 0;
   int                          send_idle_pct = 0;
   int                          rsp_stall_pct = 0;

   byterun1_run_length_decoder_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_frame_size  (csr_frame_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the decoder hangs
   initial begin
      #(30_000_000);
      $display("** byterun1_run_length_decoder_unit: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   // count one decoded byte; true when it completes the frame
   function automatic logic count_decoded();
      bytes_written = bytes_written + 1'b1;
      if (bytes_written == frame_size[COUNT_WIDTH-1:0]) begin
         bytes_written = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // step the decoder on one accepted byte, queueing the items it yields
   function automatic void predict_decode(input logic [7:0] b);
      decoded_item_type item;
      int               lanes;
      logic             fe;
      int               n;
      n = 0;
      case (dec_phase)
         DEC_CONTROL: begin
            if (b < CTRL_NOP) begin
               run_left  = RUN_WIDTH'(int'(b) + 1);
               dec_phase = DEC_LITERAL;
            end else if (b != CTRL_NOP) begin
               run_left  = RUN_WIDTH'(257 - int'(b));
               dec_phase = DEC_REPEAT;
            end
         end
         DEC_LITERAL: begin
            fe   = count_decoded();
            item = '{b, 8'h00, BYTES_ONE, 1'b1, fe};
            decoded_q.push_back(item);
            if (run_left > 0) run_left--;
            if (run_left == 0) dec_phase = DEC_CONTROL;
            else dec_phase = fe ? DEC_DROP : DEC_LITERAL;
         end
         DEC_DROP: begin
            if (run_left > 0) run_left--;
            if (run_left == 0) dec_phase = DEC_CONTROL;
         end
         default: begin
            // repeat data: up to two copies per item, cut short at frame end
            while (run_left > 0 && n < MAX_RESULTS) begin
               lanes = 0;
               fe    = 1'b0;
               while (lanes < OUT_LANES && run_left > 0 && !fe) begin
                  lanes++;
                  run_left--;
                  fe = count_decoded();
               end
               if (fe) run_left = '0;
               item.first_byte  = b;
               item.second_byte = (lanes == OUT_LANES) ? b : 8'h00;
               item.byte_count  = (lanes == OUT_LANES) ? BYTES_TWO : BYTES_ONE;
               item.last_of_run = (run_left == 0);
               item.frame_end   = fe;
               decoded_q.push_back(item);
               n++;
            end
            run_left  = '0;
            dec_phase = DEC_CONTROL;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string field, input logic [7:0] expected,
                              input logic [7:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_decoded
      decoded_item_type exp_item;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $error("decoded item with none expected: first_byte %0d byte_count %0d",
                   rsp_first_byte, rsp_byte_count);
            fail_count++;
         end else begin
            exp_item = decoded_q.pop_front();
            check_field("first_byte", exp_item.first_byte, rsp_first_byte);
            check_field("second_byte", exp_item.second_byte, rsp_second_byte);
            check_field("byte_count", 8'(exp_item.byte_count), 8'(rsp_byte_count));
            check_field("last_of_run", 8'(exp_item.last_of_run), 8'(rsp_last_of_run));
            check_field("frame_end", 8'(exp_item.frame_end), 8'(rsp_frame_end));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------- driving

   // offer one compressed byte, hold it until taken, then predict
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_decode(b);
   endtask

   // stop sending and let every expected item come out
   task automatic wait_decoded_drain();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, decoder idle
   task automatic write_csr(input logic [FRAME_SIZE_WIDTH-1:0] size);
      csr_valid      <= 1'b1;
      csr_frame_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      frame_size  = size;
   endtask

   // run the current frame to its end so the byte count is back at zero
   task automatic flush_frame();
      while (dec_phase != DEC_CONTROL) send_byte(8'($urandom));
      if (bytes_written != 0) begin
         // shrink the frame so that one literal byte closes it
         wait_decoded_drain();
         write_csr(FRAME_SIZE_WIDTH'(bytes_written + 1'b1));
         send_byte(CTRL_LIT_SHORTEST);
         send_byte(8'($urandom));
      end
   endtask

   task automatic write_frame_size(input logic [FRAME_SIZE_WIDTH-1:0] size);
      wait_decoded_drain();
      // the counter must sit below the new size, or the frame would wrap
      if (bytes_written >= size) begin
         flush_frame();
         wait_decoded_drain();
      end
      write_csr(size);
   endtask

   // mostly well-formed runs with random content, some noise bytes
   task automatic run_random_stream(input int n_items);
      int   sent;
      int   pick;
      int   len;
      logic paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_byte(8'($urandom));
            sent++;
         end else if (pick < 18) begin
            send_byte(CTRL_NOP);
            sent++;
         end else if (pick < 58) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
                                              : $urandom_range(1, 6);
            send_byte(8'(len - 1));
            repeat (len) send_byte(8'($urandom));
            sent += len + 1;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 128)
                                              : $urandom_range(2, 9);
            send_byte(8'(257 - len));
            send_byte(8'($urandom));
            sent += 2;
         end
         // hold the sender back once until the output has emptied
         if (!paused && sent >= n_items / 2) begin
            wait_decoded_drain();
            paused = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // every control kind and data extremes at the reset frame size
   task automatic test_directed_runs();
      send_byte(CTRL_NOP);
      send_byte(CTRL_LIT_SHORTEST);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(CTRL_REP_SHORTEST);
      send_byte(8'hC3);
      send_byte(8'hFE);             // repeat of three: last item has one byte
      send_byte(8'h3C);
      send_byte(CTRL_REP_LONGEST);  // longest repeat, most items per byte
      send_byte(8'hFF);
      send_byte(CTRL_LIT_LONGEST);  // longest literal, finished by the flush
      send_byte(8'hA5);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // frame end inside repeats and literals, down to a one-byte frame
   task automatic test_frame_end();
      write_frame_size(FRAME_SIZE_WIDTH'(5));
      send_byte(CTRL_REP_LONGEST);  // 2 + 2 + 1, rest of the repeat dropped
      send_byte(8'h11);
      send_byte(8'h03);
      repeat (4) send_byte(8'($urandom));
      send_byte(8'h03);             // frame ends on first byte, three dropped
      repeat (4) send_byte(8'($urandom));
      send_byte(8'hFD);
      send_byte(8'h22);
      send_byte(CTRL_LIT_SHORTEST);
      send_byte(8'h33);
      write_frame_size(FRAME_SIZE_MIN);
      send_byte(CTRL_REP_SHORTEST); // single-byte item closes the repeat
      send_byte(8'h44);
      send_byte(8'h02);
      repeat (3) send_byte(8'($urandom));
      write_frame_size(FRAME_SIZE_WIDTH'(2));
      send_byte(8'hFE);
      send_byte(8'h55);
      send_byte(CTRL_LIT_SHORTEST);
      send_byte(8'h66);
   endtask

   // random streams under each idling pattern and several frame sizes
   task automatic test_idle_phases();
      int                          send_pcts[4]  = '{0, 56, 0, 11};
      int                          stall_pcts[4] = '{0, 0, 56, 11};
      int                          counts[4]     = '{55, 55, 55, 55};
      logic [FRAME_SIZE_WIDTH-1:0] sizes[4];
      sizes = '{FRAME_SIZE_WIDTH'(37), FRAME_SIZE_WIDTH'(3),
                FRAME_SIZE_WIDTH'(200), FRAME_SIZE_WIDTH'(2)};
      for (int m = 0; m < 4; m++) begin
         write_frame_size(sizes[m]);
         send_idle_pct = send_pcts[m];
         rsp_stall_pct = stall_pcts[m];
         run_random_stream(counts[m]);
      end
   endtask

   // largest frame: no frame end is reached in the run
   task automatic test_largest_frame();
      write_frame_size(FRAME_SIZE_MAX);
      send_idle_pct = 11;
      rsp_stall_pct = 11;
      run_random_stream(45);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_runs();
      test_frame_end();
      test_idle_phases();
      test_largest_frame();
      wait_decoded_drain();
      if (fail_count == 0) begin
         $display("** byterun1_run_length_decoder_unit: PASSED **");
      end else begin
         $display("** byterun1_run_length_decoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
